FILE: rtl/pmlp_pkg.sv
package pmlp_pkg;

  localparam int NAME_MAX_LEN = 1024;
  localparam int NAME_LEN_W   = $clog2(NAME_MAX_LEN + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BRACK = 8'h5B;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [3:0] PERM_R = 4'b0001;
  localparam logic [3:0] PERM_W = 4'b0010;
  localparam logic [3:0] PERM_X = 4'b0100;
  localparam logic [3:0] PERM_S = 4'b1000;

  // one character after decode
  typedef struct packed {
    logic       hex_ok;
    logic [3:0] digit;
    logic       dec_ok;
    logic       is_nul;
    logic       is_nl;
    logic       is_sp;
    logic       is_dash;
    logic       is_colon;
    logic       is_name_start;
    logic       is_r;
    logic       is_w;
    logic       is_x;
    logic       is_s;
    logic       is_p;
  } byte_cls_t;

endpackage

FILE: rtl/pmlp_if.sv
interface pmlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface pmlp_rec_if;
  logic        valid;
  logic        ready;
  logic [63:0] start_addr;
  logic [63:0] end_addr;
  logic [63:0] region_size;
  logic [63:0] file_offset;
  logic [11:0] dev_major;
  logic [19:0] dev_minor;
  logic [63:0] inode;
  logic [2:0]  prot_bits;
  logic        is_shared;
  logic        is_anonymous;
  logic        format_error;

  modport source(output valid, output start_addr, output end_addr, output region_size,
                 output file_offset, output dev_major, output dev_minor, output inode,
                 output prot_bits, output is_shared, output is_anonymous,
                 output format_error, input ready);
  modport sink(input valid, input start_addr, input end_addr, input region_size,
               input file_offset, input dev_major, input dev_minor, input inode,
               input prot_bits, input is_shared, input is_anonymous,
               input format_error, output ready);
endinterface

FILE: rtl/pmlp_front.sv
module pmlp_front (
  input  logic                clk,
  input  logic                rst,
  pmlp_byte_if.sink           in_ch,
  output pmlp_pkg::byte_cls_t q_data,
  output logic                q_valid,
  input  logic                q_ready
);
  import pmlp_pkg::*;

  byte_cls_t             cls;
  byte_cls_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  push;
  logic                  pop;

  always_comb begin
    logic [7:0] b;
    b = in_ch.in_byte;
    cls = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      cls.hex_ok = 1'b1;
      cls.dec_ok = 1'b1;
      cls.digit  = b[3:0];
    end else if (b >= 8'h61 && b <= 8'h66) begin
      cls.hex_ok = 1'b1;
      cls.digit  = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      cls.hex_ok = 1'b1;
      cls.digit  = 4'(b - 8'h37);
    end
    cls.is_nul        = (b == CH_NUL);
    cls.is_nl         = (b == CH_NL);
    cls.is_sp         = (b == CH_SP);
    cls.is_dash       = (b == CH_DASH);
    cls.is_colon      = (b == CH_COLON);
    cls.is_name_start = (b == CH_SLASH) || (b == CH_BRACK) || (b == CH_PAREN);
    cls.is_r          = (b == CH_R);
    cls.is_w          = (b == CH_W);
    cls.is_x          = (b == CH_X);
    cls.is_s          = (b == CH_S);
    cls.is_p          = (b == CH_P);
  end

  assign in_ch.ready = (count != CNT_W'(FIFO_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      unique case ({push, pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");
  a_push_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop && count == '0 |=> q_valid)
    else $error("pushed entry not visible");
  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/pmlp_back.sv
module pmlp_back (
  input  logic                clk,
  input  logic                rst,
  input  pmlp_pkg::byte_cls_t q_data,
  input  logic                q_valid,
  output logic                q_ready,
  pmlp_rec_if.source          out_ch
);
  import pmlp_pkg::*;

  typedef enum logic [4:0] {
    PH_LINE, PH_START, PH_END, PH_R, PH_W, PH_X, PH_S, PH_SP,
    PH_OFF, PH_MAJ, PH_MIN, PH_INO, PH_GAP, PH_NAME, PH_SKIP
  } phase_t;

  phase_t                parse_phase, parse_phase_next;
  logic [63:0]           accumulator, accumulator_next;
  logic [63:0]           start_reg, start_reg_next;
  logic [63:0]           end_reg, end_reg_next;
  logic [63:0]           offset_reg, offset_reg_next;
  logic [11:0]           major_reg, major_reg_next;
  logic [19:0]           minor_reg, minor_reg_next;
  logic [3:0]            perm_bits, perm_bits_next;
  logic [NAME_LEN_W-1:0] name_length, name_length_next;
  logic                  error_seen, error_seen_next;

  logic                  take;
  logic                  emit_c;
  logic                  emit_bad;
  logic                  anon_c;
  logic [63:0]           acc_hex;
  logic [63:0]           acc_dec;
  logic [NAME_LEN_W-1:0] name_inc;

  logic                  rec_valid;
  logic [63:0]           rec_start, rec_end, rec_size, rec_offset, rec_inode;
  logic [11:0]           rec_major;
  logic [19:0]           rec_minor;
  logic [2:0]            rec_prot;
  logic                  rec_shared, rec_anon, rec_err;

  localparam logic [NAME_LEN_W-1:0] NAME_LIMIT = NAME_LEN_W'(NAME_MAX_LEN);

  assign take     = q_valid && (!rec_valid || out_ch.ready);
  assign q_ready  = !rec_valid || out_ch.ready;
  assign name_inc = NAME_LEN_W'(name_length + 1'b1);

  always_comb begin
    logic [63:0] a;
    logic        fail_c;
    a = (parse_phase == PH_LINE) ? 64'd0 : accumulator;
    acc_hex = {a[59:0], q_data.digit};
    // x10 as x8 + x2
    acc_dec = {accumulator[60:0], 3'b000} + {accumulator[62:0], 1'b0}
              + {60'd0, q_data.digit};
    parse_phase_next = parse_phase;
    accumulator_next = accumulator;
    start_reg_next   = start_reg;
    end_reg_next     = end_reg;
    offset_reg_next  = offset_reg;
    major_reg_next   = major_reg;
    minor_reg_next   = minor_reg;
    perm_bits_next   = perm_bits;
    name_length_next = name_length;
    error_seen_next  = error_seen;
    fail_c   = 1'b0;
    emit_c   = 1'b0;
    emit_bad = 1'b0;
    anon_c   = 1'b1;
    if (take && !(parse_phase == PH_LINE && q_data.is_nul)) begin
      if (parse_phase == PH_LINE) begin
        accumulator_next = '0;
        start_reg_next   = '0;
        end_reg_next     = '0;
        offset_reg_next  = '0;
        major_reg_next   = '0;
        minor_reg_next   = '0;
        perm_bits_next   = '0;
        name_length_next = '0;
        error_seen_next  = 1'b0;
        parse_phase_next = PH_START;
      end
      unique case (parse_phase)
        PH_LINE, PH_START: begin
          if (q_data.hex_ok) begin
            accumulator_next = acc_hex;
          end else begin
            start_reg_next = a;
            if (a == '0 || !q_data.is_dash) begin
              fail_c = 1'b1;
            end else begin
              accumulator_next = '0;
              parse_phase_next = PH_END;
            end
          end
        end
        PH_END: begin
          if (q_data.hex_ok) begin
            accumulator_next = acc_hex;
          end else begin
            end_reg_next = accumulator;
            if (accumulator == '0 || !q_data.is_sp || accumulator < start_reg) begin
              fail_c = 1'b1;
            end else begin
              accumulator_next = '0;
              parse_phase_next = PH_R;
            end
          end
        end
        PH_R: begin
          if (q_data.is_r) perm_bits_next = perm_bits | PERM_R;
          if (q_data.is_r || q_data.is_dash) parse_phase_next = PH_W;
          else fail_c = 1'b1;
        end
        PH_W: begin
          if (q_data.is_w) perm_bits_next = perm_bits | PERM_W;
          if (q_data.is_w || q_data.is_dash) parse_phase_next = PH_X;
          else fail_c = 1'b1;
        end
        PH_X: begin
          if (q_data.is_x) perm_bits_next = perm_bits | PERM_X;
          if (q_data.is_x || q_data.is_dash) parse_phase_next = PH_S;
          else fail_c = 1'b1;
        end
        PH_S: begin
          if (q_data.is_s) perm_bits_next = perm_bits | PERM_S;
          if (q_data.is_s || q_data.is_p) parse_phase_next = PH_SP;
          else fail_c = 1'b1;
        end
        PH_SP: begin
          if (q_data.is_sp) begin
            accumulator_next = '0;
            parse_phase_next = PH_OFF;
          end else begin
            fail_c = 1'b1;
          end
        end
        PH_OFF: begin
          if (q_data.hex_ok) begin
            accumulator_next = acc_hex;
          end else if (!q_data.is_sp) begin
            fail_c = 1'b1;
          end else begin
            offset_reg_next  = accumulator;
            accumulator_next = '0;
            parse_phase_next = PH_MAJ;
          end
        end
        PH_MAJ: begin
          if (q_data.hex_ok) begin
            accumulator_next = acc_hex;
          end else if (!q_data.is_colon) begin
            fail_c = 1'b1;
          end else begin
            major_reg_next   = accumulator[11:0];
            accumulator_next = '0;
            parse_phase_next = PH_MIN;
          end
        end
        PH_MIN: begin
          if (q_data.hex_ok) begin
            accumulator_next = acc_hex;
          end else if (!q_data.is_sp) begin
            fail_c = 1'b1;
          end else begin
            minor_reg_next   = accumulator[19:0];
            accumulator_next = '0;
            parse_phase_next = PH_INO;
          end
        end
        PH_INO, PH_GAP: begin
          if (parse_phase == PH_INO && q_data.dec_ok) begin
            accumulator_next = acc_dec;
          end else if (q_data.is_sp) begin
            parse_phase_next = PH_GAP;
          end else if (q_data.is_name_start) begin
            name_length_next = NAME_LEN_W'(1);
            if (NAME_LEN_W'(1) >= NAME_LIMIT) fail_c = 1'b1;
            else parse_phase_next = PH_NAME;
          end else if (q_data.is_nl) begin
            emit_c = 1'b1;
          end else begin
            fail_c = 1'b1;
          end
        end
        PH_NAME: begin
          if (q_data.is_nl) begin
            emit_c = 1'b1;
            anon_c = 1'b0;
          end else begin
            name_length_next = name_inc;
            if (name_inc >= NAME_LIMIT) fail_c = 1'b1;
          end
        end
        PH_SKIP: begin
          if (q_data.is_nl) fail_c = 1'b1;
        end
        default: begin
          parse_phase_next = PH_SKIP;
        end
      endcase
      if (fail_c) begin
        error_seen_next = 1'b1;
        if (q_data.is_nl) begin
          emit_c   = 1'b1;
          emit_bad = 1'b1;
        end else begin
          parse_phase_next = PH_SKIP;
        end
      end
      if (emit_c) parse_phase_next = PH_LINE;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_c) begin
      if (emit_bad) begin
        rec_start  <= '0;
        rec_end    <= '0;
        rec_size   <= '0;
        rec_offset <= '0;
        rec_major  <= '0;
        rec_minor  <= '0;
        rec_inode  <= '0;
        rec_prot   <= '0;
        rec_shared <= 1'b0;
        rec_anon   <= 1'b0;
        rec_err    <= 1'b1;
      end else begin
        rec_start  <= start_reg;
        rec_end    <= end_reg;
        rec_size   <= end_reg - start_reg;
        rec_offset <= offset_reg;
        rec_major  <= major_reg;
        rec_minor  <= minor_reg;
        rec_inode  <= accumulator;
        rec_prot   <= perm_bits[2:0];
        rec_shared <= perm_bits[3];
        rec_anon   <= anon_c;
        rec_err    <= 1'b0;
      end
    end
    if (rst) begin
      parse_phase <= PH_LINE;
      error_seen  <= 1'b0;
      rec_valid   <= 1'b0;
      accumulator <= '0;
      start_reg   <= '0;
      end_reg     <= '0;
      offset_reg  <= '0;
      major_reg   <= '0;
      minor_reg   <= '0;
      perm_bits   <= '0;
      name_length <= '0;
    end else begin
      parse_phase <= parse_phase_next;
      error_seen  <= error_seen_next;
      accumulator <= accumulator_next;
      start_reg   <= start_reg_next;
      end_reg     <= end_reg_next;
      offset_reg  <= offset_reg_next;
      major_reg   <= major_reg_next;
      minor_reg   <= minor_reg_next;
      perm_bits   <= perm_bits_next;
      name_length <= name_length_next;
      if (emit_c) rec_valid <= 1'b1;
      else if (out_ch.ready) rec_valid <= 1'b0;
    end
  end

  assign out_ch.valid        = rec_valid;
  assign out_ch.start_addr   = rec_start;
  assign out_ch.end_addr     = rec_end;
  assign out_ch.region_size  = rec_size;
  assign out_ch.file_offset  = rec_offset;
  assign out_ch.dev_major    = rec_major;
  assign out_ch.dev_minor    = rec_minor;
  assign out_ch.inode        = rec_inode;
  assign out_ch.prot_bits    = rec_prot;
  assign out_ch.is_shared    = rec_shared;
  assign out_ch.is_anonymous = rec_anon;
  assign out_ch.format_error = rec_err;

`ifndef ASSERT_OFF
  a_good_range: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_err |-> rec_start != '0 && rec_end >= rec_start)
    else $error("good record with bad address range");
  a_bad_zeroed: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_err |-> rec_start == '0 && rec_prot == '0 && !rec_anon)
    else $error("error record carries data");
  a_skip_err: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_SKIP |-> error_seen)
    else $error("skipping without error");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !out_ch.ready |=> rec_valid)
    else $error("record dropped while stalled");
`endif

endmodule

FILE: rtl/proc_maps_line_parser_core.sv
// Memory-map line parser: one character in per cycle, one record out per newline.
// A newline is decoded into the queue, then parsed and registered as a record;
// a stalled record can hold it in the queue ahead of the parse step.
// Throughput: 1 byte/cycle sustained while the record output is taken; a stalled
// record holds the back end, and the two-entry queue absorbs the front.
// Reset (rst, synchronous): queue emptied, parse at line start, no record pending.
module proc_maps_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  pmlp_byte_if.sink   in_ch,
  pmlp_rec_if.source  out_ch
);
  import pmlp_pkg::*;

  byte_cls_t q_data;
  logic      q_valid;
  logic      q_ready;

  pmlp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  pmlp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/proc_maps_line_parser_core_tb.sv
module proc_maps_line_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmlp_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES    = 20;
  localparam int RAND_LINES     = 4;

  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_A_LO = "a";
  localparam logic [7:0] CH_F_LO = "f";
  localparam logic [7:0] CH_A_UP = "A";
  localparam logic [7:0] CH_F_UP = "F";
  localparam logic [7:0] CH_HIGH = 8'hFF;

  typedef enum logic [3:0] {
    PS_LINE, PS_START, PS_END, PS_R, PS_W, PS_X, PS_S, PS_SP,
    PS_OFF, PS_MAJ, PS_MIN, PS_INO, PS_GAP, PS_NAME, PS_SKIP
  } parse_ph_e;

  typedef struct packed {
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [63:0] region_size;
    logic [63:0] file_offset;
    logic [11:0] dev_major;
    logic [19:0] dev_minor;
    logic [63:0] inode;
    logic [2:0]  prot_bits;
    logic        is_shared;
    logic        is_anonymous;
    logic        format_error;
  } map_rec_t;

  typedef struct {
    logic [7:0] ch;
    bit         quiet;  // no sender gap after this byte
    bit         drain;  // wait for all records before offering
    bit         mark;   // starts the long receiver hold
  } char_item_t;

  logic clk = 1'b0;
  logic rst;

  pmlp_byte_if in_ch();
  pmlp_rec_if  out_ch();

  proc_maps_line_parser_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  char_item_t char_q[$];
  map_rec_t   rec_expect_q[$];
  logic [7:0] line_buf[$];

  int  mismatch_cnt = 0;
  int  idle_cycles  = 0;
  int  tx_gap       = 0;
  int  rx_wait      = 0;
  int  hold_left    = 0;
  bit  rx_calm      = 1'b0;
  bit  hold_req     = 1'b0;
  bit  cur_mark     = 1'b0;
  bit  byte_took    = 1'b0;
  bit  rec_took     = 1'b0;

  // line parser shadow state
  parse_ph_e   ph = PS_LINE;
  logic [63:0] acc = '0;
  logic [63:0] start_r = '0;
  logic [63:0] end_r = '0;
  logic [63:0] offset_r = '0;
  logic [11:0] major_r = '0;
  logic [19:0] minor_r = '0;
  logic [3:0]  perm = '0;
  int          name_len = 0;
  bit          line_bad = 1'b0;

  function automatic int hex_digit(logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_A_LO && b <= CH_F_LO) return int'(b - CH_A_LO) + 10;
    if (b >= CH_A_UP && b <= CH_F_UP) return int'(b - CH_A_UP) + 10;
    return -1;
  endfunction

  function automatic bit name_start(logic [7:0] b);
    return b == CH_SLASH || b == CH_BRACK || b == CH_PAREN;
  endfunction

  task automatic close_line(bit anon);
    map_rec_t r;
    r = '0;
    if (line_bad) begin
      r.format_error = 1'b1;
    end else begin
      r.start_addr   = start_r;
      r.end_addr     = end_r;
      r.region_size  = end_r - start_r;
      r.file_offset  = offset_r;
      r.dev_major    = major_r;
      r.dev_minor    = minor_r;
      r.inode        = acc;
      r.prot_bits    = perm[2:0];
      r.is_shared    = perm[3];
      r.is_anonymous = anon;
    end
    rec_expect_q.push_back(r);
    ph = PS_LINE;
  endtask

  task automatic line_fail(logic [7:0] b);
    line_bad = 1'b1;
    if (b == CH_NL) begin
      close_line(1'b1);
    end else begin
      ph = PS_SKIP;
    end
  endtask

  task automatic name_begin(logic [7:0] b);
    name_len = 1;
    if (name_len >= NAME_MAX_LEN) begin
      line_fail(b);
    end else begin
      ph = PS_NAME;
    end
  endtask

  task automatic take_flag(logic [7:0] b, logic [7:0] set_ch, logic [7:0] alt_ch,
                           logic [3:0] bitv, parse_ph_e nxt);
    if (b == set_ch) begin
      perm |= bitv;
    end else if (b != alt_ch) begin
      line_fail(b);
      return;
    end
    ph = nxt;
  endtask

  task automatic parse_byte(logic [7:0] b);
    int d;
    d = hex_digit(b);
    if (ph == PS_LINE) begin
      if (b == CH_NUL) return;
      acc      = '0;
      start_r  = '0;
      end_r    = '0;
      offset_r = '0;
      major_r  = '0;
      minor_r  = '0;
      perm     = '0;
      name_len = 0;
      line_bad = 1'b0;
      ph       = PS_START;
    end
    case (ph)
      PS_START: begin
        if (d >= 0) begin
          acc = acc * 64'd16 + 64'(d);
        end else begin
          start_r = acc;
          if (start_r == 0 || b != CH_DASH) begin
            line_fail(b);
          end else begin
            acc = '0;
            ph  = PS_END;
          end
        end
      end
      PS_END: begin
        if (d >= 0) begin
          acc = acc * 64'd16 + 64'(d);
        end else begin
          end_r = acc;
          if (end_r == 0 || b != CH_SP || end_r < start_r) begin
            line_fail(b);
          end else begin
            acc = '0;
            ph  = PS_R;
          end
        end
      end
      PS_R: take_flag(b, CH_R, CH_DASH, PERM_R, PS_W);
      PS_W: take_flag(b, CH_W, CH_DASH, PERM_W, PS_X);
      PS_X: take_flag(b, CH_X, CH_DASH, PERM_X, PS_S);
      PS_S: take_flag(b, CH_S, CH_P, PERM_S, PS_SP);
      PS_SP: begin
        if (b != CH_SP) begin
          line_fail(b);
        end else begin
          acc = '0;
          ph  = PS_OFF;
        end
      end
      PS_OFF: begin
        if (d >= 0) begin
          acc = acc * 64'd16 + 64'(d);
        end else if (b != CH_SP) begin
          line_fail(b);
        end else begin
          offset_r = acc;
          acc      = '0;
          ph       = PS_MAJ;
        end
      end
      PS_MAJ: begin
        if (d >= 0) begin
          acc = acc * 64'd16 + 64'(d);
        end else if (b != CH_COLON) begin
          line_fail(b);
        end else begin
          major_r = acc[11:0];
          acc     = '0;
          ph      = PS_MIN;
        end
      end
      PS_MIN: begin
        if (d >= 0) begin
          acc = acc * 64'd16 + 64'(d);
        end else if (b != CH_SP) begin
          line_fail(b);
        end else begin
          minor_r = acc[19:0];
          acc     = '0;
          ph      = PS_INO;
        end
      end
      PS_INO: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          acc = acc * 64'd10 + 64'(b - CH_ZERO);
        end else if (b == CH_SP) begin
          ph = PS_GAP;
        end else if (name_start(b)) begin
          name_begin(b);
        end else if (b == CH_NL) begin
          close_line(1'b1);
        end else begin
          line_fail(b);
        end
      end
      PS_GAP: begin
        if (b != CH_SP) begin
          if (name_start(b)) begin
            name_begin(b);
          end else if (b == CH_NL) begin
            close_line(1'b1);
          end else begin
            line_fail(b);
          end
        end
      end
      PS_NAME: begin
        if (b == CH_NL) begin
          close_line(1'b0);
        end else begin
          name_len++;
          if (name_len >= NAME_MAX_LEN) line_fail(b);
        end
      end
      default: begin
        if (b == CH_NL) begin
          line_bad = 1'b1;
          close_line(1'b1);
        end
      end
    endcase
  endtask

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", fname, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_record();
    map_rec_t want_r;
    if (rec_expect_q.size() == 0) begin
      $error("record transfer with no line pending");
      mismatch_cnt++;
      return;
    end
    want_r = rec_expect_q.pop_front();
    check_field("start_addr", want_r.start_addr, out_ch.start_addr);
    check_field("end_addr", want_r.end_addr, out_ch.end_addr);
    check_field("region_size", want_r.region_size, out_ch.region_size);
    check_field("file_offset", want_r.file_offset, out_ch.file_offset);
    check_field("dev_major", 64'(want_r.dev_major), 64'(out_ch.dev_major));
    check_field("dev_minor", 64'(want_r.dev_minor), 64'(out_ch.dev_minor));
    check_field("inode", want_r.inode, out_ch.inode);
    check_field("prot_bits", 64'(want_r.prot_bits), 64'(out_ch.prot_bits));
    check_field("is_shared", 64'(want_r.is_shared), 64'(out_ch.is_shared));
    check_field("is_anonymous", 64'(want_r.is_anonymous), 64'(out_ch.is_anonymous));
    check_field("format_error", 64'(want_r.format_error), 64'(out_ch.format_error));
  endtask

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    byte_took = 1'b0;
    rec_took  = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        byte_took = 1'b1;
        parse_byte(in_ch.in_byte);
        if (cur_mark) hold_req = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        rec_took = 1'b1;
        check_record();
      end
      if (byte_took || rec_took) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nb;
    char_item_t nxt;
    nv = in_ch.valid;
    nb = in_ch.in_byte;
    if (!rst) begin
      if (byte_took) nv = 1'b0;
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (char_q.size() != 0 &&
                     !(char_q[0].drain && rec_expect_q.size() != 0)) begin
          nxt      = char_q.pop_front();
          nb       = nxt.ch;
          nv       = 1'b1;
          cur_mark = nxt.mark;
          tx_gap   = nxt.quiet ? 0 : $urandom_range(13, 0);
        end
      end
    end
    in_ch.valid   <= nv;
    in_ch.in_byte <= nb;
  end

  // record receiver
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (rec_took) begin
          rx_wait = rx_calm ? 0 : $urandom_range(13, 0);
          if ($urandom_range(7, 0) == 0) rx_calm = !rx_calm;
        end
        if (rx_wait > 0) begin
          rx_wait--;
        end else begin
          nr = 1'b1;
        end
      end
    end
    out_ch.ready <= nr;
  end

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_nibble(logic [3:0] n);
    if (n < 10) begin
      line_buf.push_back(CH_ZERO + 8'(n));
    end else begin
      line_buf.push_back(($urandom_range(1, 0) ? CH_A_UP : CH_A_LO) + 8'(n - 10));
    end
  endtask

  task automatic put_hex(logic [63:0] v, int lead);
    int nd;
    nd = 1;
    for (int i = 1; i < 16; i++) if (v[4*i +: 4] != 0) nd = i + 1;
    repeat (lead) line_buf.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) put_nibble(v[4*i +: 4]);
  endtask

  task automatic put_rand_hex(int n);
    repeat (n) put_nibble(4'($urandom_range(15, 0)));
  endtask

  task automatic put_dec(logic [63:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[i]) line_buf.push_back(digs[i]);
  endtask

  task automatic put_rand_dec(int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9, 0)));
  endtask

  // name text: any byte but newline
  task automatic put_name_bytes(int n);
    logic [7:0] r;
    repeat (n) begin
      r = 8'($urandom_range(255, 0));
      if (r == CH_NL) r = CH_NUL;
      line_buf.push_back(r);
    end
  endtask

  task automatic put_name_start();
    case ($urandom_range(2, 0))
      0:       line_buf.push_back(CH_SLASH);
      1:       line_buf.push_back(CH_BRACK);
      default: line_buf.push_back(CH_PAREN);
    endcase
  endtask

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(15, 0) == 0) return {64{1'b1}};
    return v >> (64 - $urandom_range(64, 1));
  endfunction

  task automatic commit_line(bit quiet, bit drain, bit mark);
    char_item_t it;
    foreach (line_buf[i]) begin
      it.ch    = line_buf[i];
      it.quiet = quiet;
      it.drain = drain && i == 0;
      it.mark  = mark && i == 0;
      char_q.push_back(it);
    end
    line_buf.delete();
  endtask

  task automatic push_line(string s);
    put_str(s);
    commit_line(1'b0, 1'b0, 1'b0);
  endtask

  task automatic build_map_line();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = rand_wide();
    if (lo == 0) lo = 64'd1;
    case ($urandom_range(3, 0))
      0:       hi = lo;
      1:       hi = lo + 64'($urandom_range(4096, 1));
      default: hi = lo + (rand_wide() >> 1);
    endcase
    if (hi < lo) hi = {64{1'b1}};
    put_hex(lo, $urandom_range(2, 0));
    line_buf.push_back(CH_DASH);
    put_hex(hi, $urandom_range(2, 0));
    line_buf.push_back(CH_SP);
    line_buf.push_back($urandom_range(1, 0) ? CH_R : CH_DASH);
    line_buf.push_back($urandom_range(1, 0) ? CH_W : CH_DASH);
    line_buf.push_back($urandom_range(1, 0) ? CH_X : CH_DASH);
    line_buf.push_back($urandom_range(1, 0) ? CH_S : CH_P);
    line_buf.push_back(CH_SP);
    if ($urandom_range(7, 0) != 0) put_hex(rand_wide(), $urandom_range(3, 0));
    line_buf.push_back(CH_SP);
    put_rand_hex($urandom_range(5, 0));
    line_buf.push_back(CH_COLON);
    put_rand_hex($urandom_range(7, 0));
    line_buf.push_back(CH_SP);
    case ($urandom_range(9, 0))
      0:       ;
      1:       put_rand_dec($urandom_range(24, 20));
      default: put_dec(rand_wide());
    endcase
    case ($urandom_range(7, 0))
      0, 1: ;
      2:       repeat ($urandom_range(3, 1)) line_buf.push_back(CH_SP);
      default: begin
        repeat ($urandom_range(12, 0)) line_buf.push_back(CH_SP);
        put_name_start();
        put_name_bytes($urandom_range(30, 0));
      end
    endcase
    line_buf.push_back(CH_NL);
  endtask

  task automatic break_line();
    int         pos;
    logic [7:0] r;
    pos = $urandom_range(line_buf.size() - 2, 0);
    if ($urandom_range(1, 0) != 0) begin
      r = 8'($urandom_range(255, 0));
      if (r == CH_NL) r = CH_HIGH;
      line_buf[pos] = r;
    end else begin
      while (line_buf.size() > pos) void'(line_buf.pop_back());
      line_buf.push_back(CH_NL);
    end
  endtask

  initial begin
    int  pick;
    bit  quiet;
    logic [7:0] r;

    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;

    // directed lines
    push_line("400000-452000 r-xp 00000000 08:02 173521      /usr/bin/dbus-daemon\n");
    push_line("00651000-00652000 rw-p 00051000 08:02 173521 /usr/bin/x\n");
    push_line("7fff2a000000-7fff2a021000 rw-p 00000000 00:00 0 [stack]\n");
    push_line("7f1-7f2 ---s 0 0:0 0\n");
    push_line("abcDEF-ABCdf0 -w-s 1F 1:2 3   \n");
    push_line("10-20 r--p 0 0:0 0 (deleted)\n");
    line_buf.push_back(CH_NUL);
    line_buf.push_back(CH_NUL);
    push_line("1-1 ---p 0 0:0 0\n");
    push_line("1-2 rwxs  : \n");
    push_line("ffffffffffffffff-FFFFFFFFFFFFFFFF rwxs ffffffffffffffff fff:fffff ");
    push_line("18446744073709551615 /\n");
    push_line("1000000000000000a-1000000000000000b r--p 123456789abcdef01 ");
    push_line("12345:123456789 123456789012345678901234 /o\n");
    push_line("\n");
    push_line("0-10 r--p 0 0:0 0\n");
    push_line("20-10 r--p 0 0:0 0\n");
    push_line("5-0 r--p 0 0:0 0\n");
    push_line("1-2 rqxp 0 0:0 0\n");
    push_line("1-2 rwxq 0 0:0 0\n");
    push_line("1_2 r junk after the error\n");
    push_line("1-2\n");
    push_line("1-2 rwxp 0 0:0 0/x\n");
    push_line("1-2 rwxp 0 0:0 0  x\n");
    push_line("1-2 rwxp 0 0;0 0\n");
    push_line("1-2 rwxp0 0:0 0\n");
    push_line("1-2 rwxp 0 0:0 12a\n");
    // name with nul and high bytes
    put_str("3-4 r--s 0 0:0 7 /");
    line_buf.push_back(CH_NUL);
    line_buf.push_back(CH_HIGH);
    line_buf.push_back(8'h80);
    push_line("\n");

    // random lines: mostly well-formed, some broken or junk
    for (int i = 0; i < RAND_LINES; i++) begin
      if ($urandom_range(5, 0) == 0) begin
        repeat ($urandom_range(3, 1)) line_buf.push_back(CH_NUL);
      end
      pick = $urandom_range(15, 0);
      if (pick == 0) begin
        line_buf.push_back(CH_NL);
      end else if (pick == 1) begin
        repeat ($urandom_range(20, 1)) begin
          r = 8'($urandom_range(255, 0));
          if (r == CH_NL) r = CH_HIGH;
          line_buf.push_back(r);
        end
        line_buf.push_back(CH_NL);
      end else begin
        build_map_line();
        if (pick <= 4) break_line();
      end
      quiet = (i >= 1 && i < 3);
      commit_line(quiet, i == 0 || i == 3, i == 1);
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (rec_expect_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && rec_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
